>>> sv/rgbc_pkg.sv
// Shared types, constants and helpers for the 3x3 RGB convolution filter.
// No dependencies; imported by every module of the block.
package rgbc_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int PIX_W      = 24;
  localparam int COL_W      = 10;
  localparam int ROW_W      = 12;
  localparam int FW_W       = 11;
  localparam int FH_W       = 13;
  localparam int CFG_ADDR_W = 3;
  localparam int PART_W     = 18;
  localparam int TOTAL_W    = 20;

  localparam logic [CFG_ADDR_W-1:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_COEF_TOP     = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_COEF_MID     = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_COEF_BOT     = 3'd4;

  localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 11'd640;
  localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 13'd480;

  localparam logic [7:0] PIX_MAX = 8'd255;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [2:0][2:0][PIX_W-1:0] win_t;
  typedef logic [2:0][PIX_W-1:0] coef_t;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             last;
  } meta_t;

  typedef struct packed {
    logic ld_row;
    logic ld_out;
  } kern_ctl_t;

  function automatic logic signed [7:0] coef_of(input logic [PIX_W-1:0] row_coefs,
                                                input logic [1:0] k);
    coef_of = $signed(row_coefs[8*k +: 8]);
  endfunction

endpackage

>>> sv/rgb_convolution_3x3.sv
// Top level of the streaming 3x3 RGB convolution filter.
// Depends on rgbc_pkg, rgbc_linebuf and rgbc_kernel.
//
// Pixels enter in raster order, one per clock at full rate; each pixel is a
// 24-bit word with channel 0 in the low byte. For every interior pixel the
// block sums the 3x3 neighborhood times the signed 8-bit coefficients, per
// channel, clamps to 0..255 and emits a word when the lower-right neighbor has
// been taken in; border pixels produce nothing. The pixel that completes a
// result passes through the input register, window, partial sums and output
// register. The pipeline sustains one pixel per clock, set by the single read
// and single write port of the line buffer memory, which is touched once per
// pixel. Stalls on the output back up through the stages; an empty stage still
// fills while the output waits. Row and column counters wrap at the end of each
// frame; tlast marks the last interior pixel. Line buffer contents start undefined
// and need no clearing pass. Write the registers only while the pipeline is empty.
module rgb_convolution_3x3 import rgbc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [23:0]           in_tdata,   // chan0, chan1, chan2
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [47:0]           out_tdata,  // out_chan0, out_chan1, out_chan2, out_col, out_row
  output logic                  out_tlast,  // frame_last
  input  logic                  cfg_wr_en,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [23:0]           cfg_wdata
);

  logic [FW_W-1:0]  width_r;
  logic [FH_W-1:0]  height_r;
  coef_t            coef_r;
  logic [COL_W-1:0] wm1;
  logic [ROW_W-1:0] hm1;

  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;

  logic             v1_r, v2_r, v3_r, out_valid_r;
  logic             emit1_r, emit2_r;
  pix_t             pix1_r;
  logic [COL_W-1:0] col1_r;
  meta_t            meta1_r, meta2_r, meta3_r, meta4_r;
  meta_t            meta_nxt;
  logic             emit_nxt;
  win_t             win_r;

  logic rdy1, rdy2, rdy3, rdy4;
  logic acc_in, mv12, mv23, mv34;

  pix_t      rd_above, rd_two;
  pix_t      res;
  kern_ctl_t kctl;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= FRAME_WIDTH_RST;
      height_r <= FRAME_HEIGHT_RST;
      coef_r   <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        REG_FRAME_WIDTH:  width_r   <= cfg_wdata[FW_W-1:0];
        REG_FRAME_HEIGHT: height_r  <= cfg_wdata[FH_W-1:0];
        REG_COEF_TOP:     coef_r[0] <= cfg_wdata;
        REG_COEF_MID:     coef_r[1] <= cfg_wdata;
        REG_COEF_BOT:     coef_r[2] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    priority if (width_r < FW_W'(3)) begin
      wm1 = COL_W'(2);
    end else if (width_r > FW_W'(MAX_WIDTH)) begin
      wm1 = COL_W'(MAX_WIDTH - 1);
    end else begin
      wm1 = COL_W'(width_r - FW_W'(1));
    end
    priority if (height_r < FH_W'(3)) begin
      hm1 = ROW_W'(2);
    end else if (height_r > FH_W'(MAX_HEIGHT)) begin
      hm1 = ROW_W'(MAX_HEIGHT - 1);
    end else begin
      hm1 = ROW_W'(height_r - FH_W'(1));
    end
  end

  assign rdy4      = !out_valid_r || out_tready;
  assign rdy3      = !v3_r || rdy4;
  assign rdy2      = !v2_r || rdy3;
  assign rdy1      = !v1_r || rdy2;
  assign in_tready = rdy1;
  assign acc_in    = in_tvalid && rdy1;
  assign mv12      = v1_r && rdy2;
  assign mv23      = v2_r && rdy3;
  assign mv34      = v3_r && rdy4;

  always_comb begin
    emit_nxt      = (row_r >= ROW_W'(2)) && (col_r >= COL_W'(2));
    meta_nxt.col  = col_r - COL_W'(1);
    meta_nxt.row  = row_r - ROW_W'(1);
    meta_nxt.last = (row_r == hm1) && (col_r == wm1);
    if (col_r >= wm1) begin
      col_nxt = '0;
      row_nxt = (row_r >= hm1) ? '0 : row_r + ROW_W'(1);
    end else begin
      col_nxt = col_r + COL_W'(1);
      row_nxt = row_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (acc_in) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
      if (rdy1) v1_r <= in_tvalid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r && emit2_r;
      if (rdy4) out_valid_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_in) begin
      pix1_r  <= in_tdata;
      col1_r  <= col_r;
      emit1_r <= emit_nxt;
      meta1_r <= meta_nxt;
    end
    if (mv12) begin
      emit2_r <= emit1_r;
      meta2_r <= meta1_r;
      for (int r = 0; r < 3; r++) begin
        win_r[r][0] <= win_r[r][1];
        win_r[r][1] <= win_r[r][2];
      end
      win_r[0][2] <= rd_two;
      win_r[1][2] <= rd_above;
      win_r[2][2] <= pix1_r;
    end
    if (mv23) meta3_r <= meta2_r;
    if (mv34) meta4_r <= meta3_r;
  end

  rgbc_linebuf u_linebuf (
    .clk      (clk),
    .rd_en    (acc_in),
    .rd_addr  (col_r),
    .wr_en    (mv12),
    .wr_addr  (col1_r),
    .wr_above (pix1_r),
    .wr_two   (rd_above),
    .rd_above (rd_above),
    .rd_two   (rd_two)
  );

  assign kctl.ld_row = mv23;
  assign kctl.ld_out = mv34;

  rgbc_kernel u_kernel (
    .clk   (clk),
    .ctl   (kctl),
    .win   (win_r),
    .coefs (coef_r),
    .res   (res)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, meta4_r.row, meta4_r.col, res};
  assign out_tlast  = meta4_r.last;

  a_linebuf_no_collision: assert property (@(posedge clk) disable iff (!rst_n)
    (acc_in && mv12) |-> (col_r != col1_r))
    else $error("line buffer read and write hit the same column");

  a_out_interior: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (meta4_r.col != '0) && (meta4_r.row != '0))
    else $error("result issued for a border pixel");

  a_last_at_corner: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && meta4_r.last) |-> (meta4_r.col == wm1 - COL_W'(1))
                                   && (meta4_r.row == hm1 - ROW_W'(1)))
    else $error("frame end flagged away from the last interior pixel");

  a_emit_only: assert property (@(posedge clk) disable iff (!rst_n)
    (mv23 && !emit2_r) |=> !v3_r)
    else $error("border pixel entered the arithmetic stages");

endmodule

>>> sv/rgbc_linebuf.sv
// Two-row line buffer: one memory of {two rows above, row above} per column.
// Depends on rgbc_pkg.
module rgbc_linebuf import rgbc_pkg::*; (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [COL_W-1:0] rd_addr,
  input  logic             wr_en,
  input  logic [COL_W-1:0] wr_addr,
  input  pix_t             wr_above,
  input  pix_t             wr_two,
  output pix_t             rd_above,
  output pix_t             rd_two
);

  logic [2*PIX_W-1:0] mem_r [MAX_WIDTH];
  logic [2*PIX_W-1:0] rd_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= {wr_two, wr_above};
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_r <= mem_r[rd_addr];
    end
  end

  assign rd_above = rd_r[PIX_W-1:0];
  assign rd_two   = rd_r[2*PIX_W-1:PIX_W];

endmodule

>>> sv/rgbc_kernel.sv
// Multiply-accumulate datapath: per-row partial sums, then total and clamp.
// Depends on rgbc_pkg.
module rgbc_kernel import rgbc_pkg::*; (
  input  logic      clk,
  input  kern_ctl_t ctl,
  input  win_t      win,
  input  coef_t     coefs,
  output pix_t      res
);

  logic signed [PART_W-1:0] part_r   [3][3];
  logic signed [PART_W-1:0] part_nxt [3][3];
  pix_t                     res_r;
  pix_t                     res_nxt;

  always_comb begin
    logic signed [16:0]       prod;
    logic signed [PART_W-1:0] acc;
    for (int ch = 0; ch < 3; ch++) begin
      for (int r = 0; r < 3; r++) begin
        acc = '0;
        for (int k = 0; k < 3; k++) begin
          prod = $signed({1'b0, win[r][k][8*ch +: 8]}) * coef_of(coefs[r], 2'(k));
          acc  = acc + {prod[16], prod};
        end
        part_nxt[ch][r] = acc;
      end
    end
  end

  always_comb begin
    logic signed [TOTAL_W-1:0] total;
    res_nxt = '0;
    for (int ch = 0; ch < 3; ch++) begin
      total = {{2{part_r[ch][0][PART_W-1]}}, part_r[ch][0]}
            + {{2{part_r[ch][1][PART_W-1]}}, part_r[ch][1]}
            + {{2{part_r[ch][2][PART_W-1]}}, part_r[ch][2]};
      if (total[TOTAL_W-1]) begin
        res_nxt[8*ch +: 8] = '0;
      end else if (total > $signed({{(TOTAL_W-8){1'b0}}, PIX_MAX})) begin
        res_nxt[8*ch +: 8] = PIX_MAX;
      end else begin
        res_nxt[8*ch +: 8] = total[7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_row) begin
      part_r <= part_nxt;
    end
    if (ctl.ld_out) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule
